// ----- hdl/three_level_priority_queue_drop_oldest_unit_defines.svh -----
// -----------------------------------------------------------------------------
// Assertion macros for the three-level priority queue
// Shared property shorthands: same-cycle and next-cycle implication.
// -----------------------------------------------------------------------------
`ifndef THREE_LEVEL_PRIORITY_QUEUE_DROP_OLDEST_UNIT_DEFINES_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_DROP_OLDEST_UNIT_DEFINES_SVH

// ante holds -> cons holds in the same cycle
`define TLPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds in the next cycle
`define TLPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tlpq_pkg.sv -----
// -----------------------------------------------------------------------------
// tlpq_pkg
// Constants, codes and types shared by the priority queue modules.
// -----------------------------------------------------------------------------
package tlpq_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int LEVELS    = 3;
  localparam int DATA_BITS = 32;
  localparam int AGE_W     = 32;

  // fixed field widths
  localparam int CMD_W     = 1;
  localparam int PRIO_W    = 2;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 2;
  localparam int ITEM_W    = 32;
  localparam int FILL_W    = 7;
  localparam int CAP_W     = 7;

  // derived sizes
  localparam int PTR_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int SLOTS  = LEVELS * MAX_ITEMS;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int LVL_W  = $clog2(LEVELS);

  // config port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_PUSHED  = 2'd0,
    STAT_DROPPED = 2'd1,
    STAT_POPPED  = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_LOAD = 1'b1
  } fsm_e;

  typedef struct packed {
    logic [AGE_W-1:0]     age;
    logic [DATA_BITS-1:0] data;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_e           status;
    logic [ITEM_W-1:0] item;
    logic [FILL_W-1:0] fill;
  } res_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(MAX_ITEMS - 1)) ? '0 : PTR_W'(ptr + 1'b1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lv,
                                                  input logic [PTR_W-1:0] ptr);
    return ADDR_W'(ADDR_W'(lv) * ADDR_W'(MAX_ITEMS) + ADDR_W'(ptr));
  endfunction

endpackage

// ----- hdl/tlpq_if.sv -----
// -----------------------------------------------------------------------------
// tlpq_in_if / tlpq_out_if
// Valid/ready channels for command beats and result beats.
// -----------------------------------------------------------------------------
interface tlpq_in_if
  import tlpq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [PRIO_W-1:0]    prio;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, cmd, prio, payload, input ready);
  modport sink   (input valid, cmd, prio, payload, output ready);
endinterface

interface tlpq_out_if
  import tlpq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ITEM_W-1:0]   item_data;
  logic [FILL_W-1:0]   fill;

  modport source (output valid, status, item_data, fill, input ready);
  modport sink   (input valid, status, item_data, fill, output ready);
endinterface

// ----- hdl/tlpq_ram.sv -----
// -----------------------------------------------------------------------------
// tlpq_ram
// Simple dual-port RAM, one write and one registered read port.
// -----------------------------------------------------------------------------
module tlpq_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 192,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/tlpq_cfg.sv -----
// -----------------------------------------------------------------------------
// tlpq_cfg
// APB capacity register and effective capacity clamp.
// -----------------------------------------------------------------------------
module tlpq_cfg
  import tlpq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CNT_W-1:0]   eff_cap_o
);

  logic [CAP_W-1:0] cap_q, cap_d;
  logic             hit;

  assign hit    = (paddr[PADDR_W-1:2] == REG_CAPACITY);
  assign pready = 1'b1;
  assign prdata = hit ? PDATA_W'(cap_q) : '0;

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && hit) begin
      cap_d = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(MAX_ITEMS);
    end else begin
      cap_q <= cap_d;
    end
  end

  // zero acts as one, anything above the store size saturates
  always_comb begin
    if (cap_q == '0) begin
      eff_cap_o = CNT_W'(1);
    end else if (32'(cap_q) > MAX_ITEMS) begin
      eff_cap_o = CNT_W'(MAX_ITEMS);
    end else begin
      eff_cap_o = CNT_W'(cap_q);
    end
  end

endmodule

// ----- hdl/tlpq_core.sv -----
// -----------------------------------------------------------------------------
// tlpq_core
// Queue control: pointers, counts, head cache, drop/pop choice, result buffer.
// -----------------------------------------------------------------------------
`include "three_level_priority_queue_drop_oldest_unit_defines.svh"

module tlpq_core
  import tlpq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CNT_W-1:0]     eff_cap_i,
  tlpq_in_if.sink              in_i,
  tlpq_out_if.source           out_o,
  output mem_req_t             mem_req_o,
  input  logic [$bits(entry_t)-1:0] mem_rdata_i
);

  fsm_e                 state_q, state_d;
  logic [PTR_W-1:0]     head_q [LEVELS];
  logic [PTR_W-1:0]     head_d [LEVELS];
  logic [PTR_W-1:0]     tail_q [LEVELS];
  logic [PTR_W-1:0]     tail_d [LEVELS];
  logic [CNT_W-1:0]     cnt_q  [LEVELS];
  logic [CNT_W-1:0]     cnt_d  [LEVELS];
  entry_t               hc_q   [LEVELS];
  entry_t               hc_d   [LEVELS];
  logic [CNT_W-1:0]     total_q, total_d;
  logic [AGE_W-1:0]     age_q, age_d;
  logic [LVL_W-1:0]     rl_q, rl_d;

  logic                 out_vld_q, out_vld_d;
  res_t                 out_q, out_d;
  logic                 sk_vld_q, sk_vld_d;
  res_t                 sk_q, sk_d;

  logic                 in_fire;
  logic                 any_ne;
  logic [LVL_W-1:0]     drop_lv;
  logic [AGE_W-1:0]     min_age;
  logic [LVL_W-1:0]     pop_lv;
  logic [LVL_W-1:0]     push_lv;
  logic                 drop;
  logic                 reload;
  logic [LVL_W-1:0]     rem_lv;
  res_t                 res;
  logic [CNT_W+1:0]     cnt_sum;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == FSM_IDLE) && !sk_vld_q;

  assign out_o.valid     = out_vld_q;
  assign out_o.status    = out_q.status;
  assign out_o.item_data = out_q.item;
  assign out_o.fill      = out_q.fill;

  // head choice: oldest head for drop (ties to higher level), first level for pop
  always_comb begin
    any_ne  = 1'b0;
    drop_lv = '0;
    min_age = '0;
    pop_lv  = '0;
    cnt_sum = '0;
    for (int lv = 0; lv < LEVELS; lv++) begin
      if (cnt_q[lv] != '0) begin
        if (!any_ne || (hc_q[lv].age < min_age)) begin
          drop_lv = LVL_W'(lv);
          min_age = hc_q[lv].age;
        end
        any_ne = 1'b1;
      end
      cnt_sum = cnt_sum + (CNT_W+2)'(cnt_q[lv]);
    end
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      if (cnt_q[lv] != '0) begin
        pop_lv = LVL_W'(lv);
      end
    end
    if (32'(in_i.prio) >= LEVELS) begin
      push_lv = LVL_W'(LEVELS - 1);
    end else begin
      push_lv = LVL_W'(in_i.prio);
    end
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    hc_d      = hc_q;
    total_d   = total_q;
    age_d     = age_q;
    rl_d      = rl_q;
    drop      = 1'b0;
    reload    = 1'b0;
    rem_lv    = '0;
    res       = '{status: STAT_EMPTY, item: '0, fill: '0};
    mem_req_o = '0;

    case (state_q)
      FSM_IDLE: begin
        if (in_fire) begin
          if (in_i.cmd == CMD_PUSH) begin
            drop  = (total_q >= eff_cap_i) && any_ne;
            age_d = age_q + 1'b1;
            res.status = STAT_PUSHED;
            if (drop) begin
              rem_lv          = drop_lv;
              reload          = (cnt_q[drop_lv] != CNT_W'(1));
              res.status      = STAT_DROPPED;
              res.item        = ITEM_W'(hc_q[drop_lv].data);
              head_d[drop_lv] = next_ptr(head_q[drop_lv]);
              cnt_d[drop_lv]  = cnt_q[drop_lv] - 1'b1;
            end else begin
              total_d = total_q + 1'b1;
            end
            // new item becomes head of an empty level straight away
            if (cnt_d[push_lv] == '0) begin
              hc_d[push_lv].age  = age_q;
              hc_d[push_lv].data = DATA_BITS'(in_i.payload);
            end
            cnt_d[push_lv]  = cnt_d[push_lv] + 1'b1;
            tail_d[push_lv] = next_ptr(tail_q[push_lv]);
            mem_req_o.we         = 1'b1;
            mem_req_o.waddr      = slot_addr(push_lv, tail_q[push_lv]);
            mem_req_o.wdata.age  = age_q;
            mem_req_o.wdata.data = DATA_BITS'(in_i.payload);
          end else if (any_ne) begin
            rem_lv         = pop_lv;
            reload         = (cnt_q[pop_lv] != CNT_W'(1));
            res.status     = STAT_POPPED;
            res.item       = ITEM_W'(hc_q[pop_lv].data);
            head_d[pop_lv] = next_ptr(head_q[pop_lv]);
            cnt_d[pop_lv]  = cnt_q[pop_lv] - 1'b1;
            total_d        = total_q - 1'b1;
          end
          res.fill = FILL_W'(total_d);
          if (reload) begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = slot_addr(rem_lv, next_ptr(head_q[rem_lv]));
            rl_d            = rem_lv;
            state_d         = FSM_LOAD;
          end
        end
      end
      FSM_LOAD: begin
        hc_d[rl_q] = entry_t'(mem_rdata_i);
        state_d    = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // output register plus skid slot
  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    sk_vld_d  = sk_vld_q;
    sk_d      = sk_q;
    if (!out_vld_q || out_o.ready) begin
      if (sk_vld_q) begin
        out_vld_d = 1'b1;
        out_d     = sk_q;
        sk_vld_d  = in_fire;
        sk_d      = res;
      end else if (in_fire) begin
        out_vld_d = 1'b1;
        out_d     = res;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (in_fire) begin
      sk_vld_d = 1'b1;
      sk_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      total_q   <= '0;
      age_q     <= '0;
      rl_q      <= '0;
      out_vld_q <= 1'b0;
      sk_vld_q  <= 1'b0;
      for (int lv = 0; lv < LEVELS; lv++) begin
        head_q[lv] <= '0;
        tail_q[lv] <= '0;
        cnt_q[lv]  <= '0;
      end
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      age_q     <= age_d;
      rl_q      <= rl_d;
      out_vld_q <= out_vld_d;
      sk_vld_q  <= sk_vld_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hc_q  <= hc_d;
    out_q <= out_d;
    sk_q  <= sk_d;
  end

  `TLPQ_ASSERT_SAME(a_total_sum, clk_i, rst_ni, 1'b1, {2'b00, total_q} == cnt_sum, "total count disagrees with level counts")
  `TLPQ_ASSERT_SAME(a_total_max, clk_i, rst_ni, 1'b1, 32'(total_q) <= MAX_ITEMS, "total count above store size")
  `TLPQ_ASSERT_SAME(a_no_take_load, clk_i, rst_ni, state_q == FSM_LOAD, !in_fire, "beat taken during head reload")
  `TLPQ_ASSERT_NEXT(a_pop_dec, clk_i, rst_ni, in_fire && (in_i.cmd == CMD_POP) && (total_q != '0), total_q == CNT_W'($past(total_q) - 1'b1), "pop did not lower fill")
  `TLPQ_ASSERT_SAME(a_skid_order, clk_i, rst_ni, sk_vld_q, out_vld_q, "skid holds a result ahead of output")

endmodule

// ----- hdl/three_level_priority_queue_drop_oldest_unit.sv -----
// -----------------------------------------------------------------------------
// three_level_priority_queue_drop_oldest_unit
// Strict-priority three-level queue with shared capacity and drop-oldest.
// -----------------------------------------------------------------------------
// Three FIFOs (level 0 high, 1 medium, 2 low) share one store and one
// capacity limit (APB register 0, byte address 0, 7 bits, reset 64; zero acts
// as one, values above 64 saturate). Each command beat gives exactly one result
// beat. A push stamps the payload with a 32-bit age; when the store already
// holds the capacity, the oldest head across all levels (lowest age, ties to the
// higher level) is dropped first and returned with status 1. A pop returns the
// head of the highest non-empty level (status 2) or status 3 when empty.
// A command that removes a head from a level that still holds items puts the
// unit in a load state, since the next head of that level is fetched from the
// slot RAM (one read port, registered read); no command is taken until the
// head is loaded; other commands need none. Results sit in an output register
// with a one-deep skid slot, so a command is still taken while one result waits.
// -----------------------------------------------------------------------------
module three_level_priority_queue_drop_oldest_unit
  import tlpq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // command and result channels
  tlpq_in_if.sink            in_i,
  tlpq_out_if.source         out_o
);

  logic [CNT_W-1:0]          eff_cap;
  mem_req_t                  mem_req;
  logic [$bits(entry_t)-1:0] mem_rdata;

  // capacity register, clamped to 1..MAX_ITEMS
  tlpq_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .eff_cap_o (eff_cap)
  );

  // pointers, counts, cached heads (age + payload per level) and sequencing
  tlpq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_cap_i   (eff_cap),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // slot store: LEVELS x MAX_ITEMS entries of {age, payload}, level-major
  tlpq_ram #(
    .WIDTH  ($bits(entry_t)),
    .DEPTH  (SLOTS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule
